// ===== rtl/core/icmpv6er_pkg.sv =====
// constants, types and checksum helper shared by the icmpv6 echo responder
package icmpv6er_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int POS_MAX         = MAX_FRAME_BYTES - 1;

  localparam int DELAY_DEPTH = 16;
  localparam int DLY_IDX_W   = $clog2(DELAY_DEPTH);

  localparam int MAC_LEN      = 6;
  localparam int IP_ADDR_LEN  = 16;
  localparam int HELD_IP_BASE = 2 * MAC_LEN;
  localparam int HELD_DEPTH   = HELD_IP_BASE + IP_ADDR_LEN;
  localparam int HELD_IDX_W   = $clog2(HELD_DEPTH);

  localparam int ETHTYPE_OFF   = 12;
  localparam int NXT_HDR_OFF   = 20;
  localparam int IP_SRC_OFF    = 22;
  localparam int IP_DST_OFF    = IP_SRC_OFF + IP_ADDR_LEN;
  localparam int ICMP_TYPE_OFF = 54;
  localparam int CSUM_LO_OFF   = 57;
  localparam int MIN_FRAME     = 62;

  localparam logic [15:0] ETHERTYPE_V6  = 16'h86DD;
  localparam logic [7:0]  NXT_HDR_ICMP  = 8'd58;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd128;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'd129;

  // old word 0x8000 -> new word 0x8100, one's complement adds
  localparam logic [17:0] CSUM_DELTA = 18'h07FFF + 18'h08100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ok;
  } item_t;

  function automatic logic [15:0] csum_echo_fix(input logic [15:0] hc);
    logic [17:0] s0;
    logic [16:0] s1;
    logic [15:0] s2;
    s0 = {2'b00, ~hc} + CSUM_DELTA;
    s1 = {1'b0, s0[15:0]} + {15'd0, s0[17:16]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    return ~s2;
  endfunction

endpackage

// ===== rtl/core/icmpv6_echo_responder.sv =====
// top level of the icmpv6 echo request to reply rewriter
//
// channel  dir  tdata             tlast       tuser
// s_axis   in   [7:0] frame byte  final byte  -
// m_axis   out  [7:0] frame byte  final byte  [0] reply_ok
//
// one request per cycle while a frame streams and the skid stage is not full;
// bytes leave 16 requests later; a final byte drains 1 to 16 bytes, input held off
// output is a register plus skid stage, so input ready does not follow m_axis_tready
// async active-low reset clears position, drain and output valids, sets verdict ok
module icmpv6_echo_responder import icmpv6er_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] reply_ok
);

  logic  itm_vld;
  logic  itm_rdy;
  item_t itm;
  item_t out_itm;

  icmpv6er_rewrite u_rewrite (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .in_byte_i (s_axis_tdata),
    .in_last_i (s_axis_tlast),
    .itm_vld_o (itm_vld),
    .itm_rdy_i (itm_rdy),
    .itm_o     (itm)
  );

  icmpv6er_skid u_skid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (itm_vld),
    .in_rdy_o  (itm_rdy),
    .in_itm_i  (itm),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_itm_o (out_itm)
  );

  assign m_axis_tdata = out_itm.data;
  assign m_axis_tlast = out_itm.last;
  assign m_axis_tuser = out_itm.ok;

endmodule

// ===== rtl/core/icmpv6er_rewrite.sv =====
// delay line, held address fields, header checks and byte rewrite
module icmpv6er_rewrite import icmpv6er_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_vld_i,
  output logic       in_rdy_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       itm_vld_o,
  input  logic       itm_rdy_i,
  output item_t      itm_o
);

  logic [DELAY_DEPTH-1:0][7:0] dly_q, dly_d;
  logic [7:0]                  held_q [HELD_DEPTH];
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [DLY_IDX_W-1:0]        idx_q, idx_d;
  logic                        ok_q, ok_d;
  logic                        flush_q, flush_d;

  logic                  accept;
  logic                  exact;
  logic [7:0]            stored;
  logic [15:0]           csum;
  logic [7:0]            rd_byte;
  logic [POS_W-1:0]      rd_pos;
  logic                  partner;
  logic                  use_held;
  logic [HELD_IDX_W-1:0] rd_idx;
  logic [7:0]            rw_byte;
  logic                  final_itm;

  assign in_rdy_o = !flush_q && itm_rdy_i;
  assign accept   = in_vld_i && in_rdy_o;
  assign exact    = pos_q < POS_W'(POS_MAX);
  assign csum     = csum_echo_fix({dly_q[0], in_byte_i});

  // byte leaving the line and its frame position
  assign rd_byte = flush_q ? dly_q[idx_q] : dly_q[DELAY_DEPTH-1];
  assign rd_pos  = flush_q ? pos_q - POS_W'(idx_q) : pos_q - POS_W'(DELAY_DEPTH);
  assign partner = !flush_q || (idx_q >= DLY_IDX_W'(MAC_LEN));

  always_comb begin
    rw_byte  = rd_byte;
    use_held = 1'b0;
    rd_idx   = '0;
    if (rd_pos < POS_W'(MAC_LEN)) begin
      use_held = partner;
      rd_idx   = HELD_IDX_W'(rd_pos + POS_W'(MAC_LEN));
    end else if (rd_pos < POS_W'(2 * MAC_LEN)) begin
      use_held = 1'b1;
      rd_idx   = HELD_IDX_W'(rd_pos - POS_W'(MAC_LEN));
    end else if (rd_pos >= POS_W'(IP_SRC_OFF) && rd_pos < POS_W'(IP_DST_OFF)) begin
      if (!flush_q) begin
        rw_byte = in_byte_i;
      end
    end else if (rd_pos >= POS_W'(IP_DST_OFF) &&
                 rd_pos < POS_W'(IP_DST_OFF + IP_ADDR_LEN)) begin
      use_held = 1'b1;
      rd_idx   = HELD_IDX_W'(rd_pos - POS_W'(IP_DST_OFF - HELD_IP_BASE));
    end
    if (use_held) begin
      rw_byte = held_q[rd_idx];
    end
    if (!exact) begin
      rw_byte = rd_byte;
    end
  end

  assign final_itm  = flush_q && (idx_q == '0);
  assign itm_vld_o  = flush_q || (in_vld_i && pos_q >= POS_W'(DELAY_DEPTH));
  assign itm_o.data = rw_byte;
  assign itm_o.last = final_itm;
  assign itm_o.ok   = final_itm && ok_q && (pos_q >= POS_W'(MIN_FRAME - 1));

  always_comb begin
    pos_d   = pos_q;
    idx_d   = idx_q;
    ok_d    = ok_q;
    flush_d = flush_q;
    dly_d   = dly_q;
    stored  = in_byte_i;
    if (accept) begin
      if (exact) begin
        if (pos_q == POS_W'(ETHTYPE_OFF) && in_byte_i != ETHERTYPE_V6[15:8]) begin
          ok_d = 1'b0;
        end
        if (pos_q == POS_W'(ETHTYPE_OFF + 1) && in_byte_i != ETHERTYPE_V6[7:0]) begin
          ok_d = 1'b0;
        end
        if (pos_q == POS_W'(NXT_HDR_OFF) && in_byte_i != NXT_HDR_ICMP) begin
          ok_d = 1'b0;
        end
        if (pos_q == POS_W'(ICMP_TYPE_OFF)) begin
          if (in_byte_i != ICMP_ECHO_REQ) begin
            ok_d = 1'b0;
          end else if (ok_q) begin
            stored = ICMP_ECHO_REP;
          end
        end
      end
      dly_d = {dly_q[DELAY_DEPTH-2:0], stored};
      if (exact && pos_q == POS_W'(CSUM_LO_OFF) && ok_d) begin
        dly_d[1] = csum[15:8];
        dly_d[0] = csum[7:0];
      end
      if (in_last_i) begin
        flush_d = 1'b1;
        idx_d   = (pos_q < POS_W'(DELAY_DEPTH - 1)) ? pos_q[DLY_IDX_W-1:0]
                                                     : DLY_IDX_W'(DELAY_DEPTH - 1);
      end else if (exact) begin
        pos_d = pos_q + POS_W'(1);
      end
    end else if (flush_q && itm_rdy_i) begin
      if (idx_q == '0) begin
        flush_d = 1'b0;
        pos_d   = '0;
        ok_d    = 1'b1;
      end else begin
        idx_d = idx_q - DLY_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      idx_q   <= '0;
      ok_q    <= 1'b1;
      flush_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      ok_q    <= ok_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q <= dly_d;
    if (accept && exact) begin
      if (pos_q < POS_W'(2 * MAC_LEN)) begin
        held_q[pos_q[HELD_IDX_W-1:0]] <= in_byte_i;
      end else if (pos_q >= POS_W'(IP_SRC_OFF) && pos_q < POS_W'(IP_DST_OFF)) begin
        held_q[HELD_IDX_W'(pos_q - POS_W'(IP_SRC_OFF - HELD_IP_BASE))] <= in_byte_i;
      end
    end
  end

endmodule

// ===== rtl/core/icmpv6er_skid.sv =====
// output register with skid stage, registered ready toward the rewrite
module icmpv6er_skid import icmpv6er_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_vld_i,
  output logic  in_rdy_o,
  input  item_t in_itm_i,
  output logic  out_vld_o,
  input  logic  out_rdy_i,
  output item_t out_itm_o
);

  logic  out_vld_q, out_vld_d;
  logic  skid_vld_q, skid_vld_d;
  item_t out_q, out_d;
  item_t skid_q, skid_d;
  logic  pop;
  logic  push;

  assign in_rdy_o  = !skid_vld_q;
  assign out_vld_o = out_vld_q;
  assign out_itm_o = out_q;
  assign pop       = out_vld_q && out_rdy_i;
  assign push      = in_vld_i && !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || pop) begin
        out_d     = in_itm_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = in_itm_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// ===== rtl/core/icmpv6er_checker.sv =====
// port-level assertions for the icmpv6 echo responder, bound to the top level
module icmpv6er_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // verdict only on the final byte
  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("reply_ok without tlast");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast, m_axis_tuser}))
    else $error("stalled output request changed");

  // drain starts after a final byte
  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during drain");

  // valid output requests carry known bits
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tlast, m_axis_tuser}))
    else $error("unknown bits on output request");

endmodule

bind icmpv6_echo_responder icmpv6er_checker u_checker (.*);
